// ===== rtl/cpf_pkg.sv =====
// shared types and constants for the checksummed packet framer
package cpf_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd253;
    localparam logic [7:0] LEN_OFFSET  = 8'd2;
    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_LF     = 8'd10;

    localparam logic [7:0] START_MARKER_RST = 8'd2;
    localparam logic [7:0] END_MARKER_RST   = 8'd3;
    localparam logic       APPEND_LE_RST    = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APPEND_LINE_END = 2'd2;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic       append_line_end;
    } t_cfg;

    // one queued command: a header or a single payload byte, with optional trailer
    typedef struct packed {
        logic       hdr;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] kind;
        logic       trailer;
        logic [7:0] chk;
    } t_cmd;

    typedef enum logic [3:0] {
        PH_BEGIN,
        PH_START,
        PH_LEN,
        PH_ADDR,
        PH_KIND,
        PH_DATA,
        PH_CHK,
        PH_END,
        PH_CR,
        PH_LF
    } t_phase;

endpackage

// ===== rtl/checksummed_packet_framer.sv =====
// top level of the checksummed packet framer
// path: an accepted input beat goes through the command queue, then the output register
// throughput: one payload beat per cycle; a start beat gives 4 output beats, 6 or 8 with the
//   trailer, a payload beat 1, or 3 or 5 when it closes the frame; the back end sends one
//   beat per cycle when ready; the input stalls while the QUEUE_DEPTH-entry queue is full
// reset: synchronous, active low; clears frame state, queue and output valid and restores
//   register defaults (start 2, end 3, line end on)
module checksummed_packet_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // dest_address, frame_kind, payload_count, payload_byte
    input  logic        i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // frame_done
    input  logic        i_cfg_we,
    input  logic [cpf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);

    cpf_pkg::t_cfg r_cfg;
    cpf_pkg::t_cmd push_cmd;
    cpf_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker    <= cpf_pkg::START_MARKER_RST;
            r_cfg.end_marker      <= cpf_pkg::END_MARKER_RST;
            r_cfg.append_line_end <= cpf_pkg::APPEND_LE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpf_pkg::CFG_START_MARKER:    r_cfg.start_marker    <= i_cfg_wdata;
                cpf_pkg::CFG_END_MARKER:      r_cfg.end_marker      <= i_cfg_wdata;
                cpf_pkg::CFG_APPEND_LINE_END: r_cfg.append_line_end <= i_cfg_wdata[0];
                default:                      r_cfg                 <= r_cfg;
            endcase
        end
    end

    cpf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .o_s_tready      (o_s_tready),
        .i_op            (i_s_tuser),
        .i_dest_address  (i_s_tdata[7:0]),
        .i_frame_kind    (i_s_tdata[15:8]),
        .i_payload_count (i_s_tdata[23:16]),
        .i_payload_byte  (i_s_tdata[31:24]),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (head_cmd),
        .i_head_valid (!q_empty),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

// ===== rtl/cpf_front.sv =====
// front end: accepts input beats, tracks frame state, builds commands
module cpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_op,
    input  logic [7:0]        i_dest_address,
    input  logic [7:0]        i_frame_kind,
    input  logic [7:0]        i_payload_count,
    input  logic [7:0]        i_payload_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output cpf_pkg::t_cmd     o_cmd
);

    logic       r_open;
    logic [7:0] r_left;
    logic [7:0] r_sum;
    logic       n_open;
    logic [7:0] n_left;
    logic [7:0] n_sum;

    logic       accept;
    logic [7:0] cnt_sat;
    logic [7:0] len;
    logic [7:0] hdr_sum;
    logic [7:0] pay_sum;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;

    assign cnt_sat = (i_payload_count > cpf_pkg::MAX_PAYLOAD) ? cpf_pkg::MAX_PAYLOAD
                                                              : i_payload_count;
    assign len     = cnt_sat + cpf_pkg::LEN_OFFSET;
    assign hdr_sum = len + i_dest_address + i_frame_kind;
    assign pay_sum = r_sum + i_payload_byte;

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_sum  = r_sum;
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            if (i_op == cpf_pkg::OP_START) begin
                o_push        = 1'b1;
                o_cmd.hdr     = 1'b1;
                o_cmd.len     = len;
                o_cmd.data    = i_dest_address;
                o_cmd.kind    = i_frame_kind;
                o_cmd.trailer = (cnt_sat == 8'd0);
                o_cmd.chk     = 8'd0 - hdr_sum;
                if (cnt_sat == 8'd0) begin
                    n_open = 1'b0;
                    n_left = 8'd0;
                    n_sum  = 8'd0;
                end else begin
                    n_open = 1'b1;
                    n_left = cnt_sat;
                    n_sum  = hdr_sum;
                end
            end else if (r_open && (r_left != 8'd0)) begin
                o_push        = 1'b1;
                o_cmd.hdr     = 1'b0;
                o_cmd.data    = i_payload_byte;
                o_cmd.trailer = (r_left == 8'd1);
                o_cmd.chk     = 8'd0 - pay_sum;
                if (r_left == 8'd1) begin
                    n_open = 1'b0;
                    n_left = 8'd0;
                    n_sum  = 8'd0;
                end else begin
                    n_left = r_left - 8'd1;
                    n_sum  = pay_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 8'd0;
            r_sum  <= 8'd0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

endmodule

// ===== rtl/cpf_queue.sv =====
// short command queue between front and back end
module cpf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output cpf_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cpf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/cpf_back.sv =====
// back end: expands commands into output bytes through a registered output stage
module cpf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpf_pkg::t_cfg i_cfg,
    input  cpf_pkg::t_cmd i_head,
    input  logic          i_head_valid,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast,
    output logic          o_m_tuser
);

    cpf_pkg::t_phase r_phase;
    cpf_pkg::t_phase n_phase;
    cpf_pkg::t_phase cur_phase;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_done;

    logic [7:0] beat_byte;
    logic       beat_last;
    logic       beat_done;
    logic       advance;

    assign cur_phase = (r_phase != cpf_pkg::PH_BEGIN) ? r_phase
                     : (i_head.hdr ? cpf_pkg::PH_START : cpf_pkg::PH_DATA);
    assign advance   = i_head_valid && (!r_valid || i_m_tready);
    assign o_pop     = advance && beat_last;

    // beat contents for the current phase
    always_comb begin
        beat_byte = 8'd0;
        beat_last = 1'b0;
        beat_done = 1'b0;
        case (cur_phase)
            cpf_pkg::PH_START: beat_byte = i_cfg.start_marker;
            cpf_pkg::PH_LEN:   beat_byte = i_head.len;
            cpf_pkg::PH_ADDR:  beat_byte = i_head.data;
            cpf_pkg::PH_KIND: begin
                beat_byte = i_head.kind;
                beat_last = !i_head.trailer;
            end
            cpf_pkg::PH_DATA: begin
                beat_byte = i_head.data;
                beat_last = !i_head.trailer;
            end
            cpf_pkg::PH_CHK:   beat_byte = i_head.chk;
            cpf_pkg::PH_END: begin
                beat_byte = i_cfg.end_marker;
                beat_last = !i_cfg.append_line_end;
                beat_done = !i_cfg.append_line_end;
            end
            cpf_pkg::PH_CR:    beat_byte = cpf_pkg::CHAR_CR;
            cpf_pkg::PH_LF: begin
                beat_byte = cpf_pkg::CHAR_LF;
                beat_last = 1'b1;
                beat_done = 1'b1;
            end
            default: beat_last = 1'b1;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (advance) begin
            if (beat_last) begin
                n_phase = cpf_pkg::PH_BEGIN;
            end else begin
                case (cur_phase)
                    cpf_pkg::PH_START: n_phase = cpf_pkg::PH_LEN;
                    cpf_pkg::PH_LEN:   n_phase = cpf_pkg::PH_ADDR;
                    cpf_pkg::PH_ADDR:  n_phase = cpf_pkg::PH_KIND;
                    cpf_pkg::PH_KIND:  n_phase = cpf_pkg::PH_CHK;
                    cpf_pkg::PH_DATA:  n_phase = cpf_pkg::PH_CHK;
                    cpf_pkg::PH_CHK:   n_phase = cpf_pkg::PH_END;
                    cpf_pkg::PH_END:   n_phase = cpf_pkg::PH_CR;
                    cpf_pkg::PH_CR:    n_phase = cpf_pkg::PH_LF;
                    default:           n_phase = cpf_pkg::PH_BEGIN;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cpf_pkg::PH_BEGIN;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data <= beat_byte;
            r_last <= beat_last;
            r_done <= beat_done;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_done;

endmodule

// ===== rtl/cpf_checker.sv =====
// port-level checks for the checksummed packet framer, bound to the top level
module cpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic       o_m_tuser
);

    // frame end only on the closing beat of an input beat's burst
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("frame end flagged on a beat that is not last");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind checksummed_packet_framer cpf_checker u_cpf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
